// File: hw/rtl/calendar_date_step_core_assert.svh
// Assertion macros for the calendar date step core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CALENDAR_DATE_STEP_CORE_ASSERT_SVH
`define CALENDAR_DATE_STEP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar_date_step_core: assertion failed");

// Next-cycle implication, disabled while in reset.
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar_date_step_core: assertion failed");

`endif

// File: hw/rtl/cds_pkg.sv
// Shared types, constants and helpers for the calendar date step core.
// No dependencies.
`default_nettype none

package cds_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int QUOT_W  = 9;   // year / 25 stays below 400
  localparam int PROD_W  = 27;  // 14-bit year times 13-bit reciprocal

  // opcodes
  localparam logic OPC_ADD = 1'b0;
  localparam logic OPC_SUB = 1'b1;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd0;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0]   LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0]   LEN_FEB   = 5'd28;
  localparam logic [DAY_W-1:0]   LEN_FEB_L = 5'd29;

  // floor(y/25) = (y * 5243) >> 17, exact for y <= 9999
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int          RECIP_SHIFT = 17;
  localparam logic [4:0]  DIV_25      = 5'd25;

  typedef struct packed {
    logic               op;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [QUOT_W-1:0]  quot;
  } clamp_t;

  typedef struct packed {
    logic               op;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   prev_len;
  } len_t;

  typedef struct packed {
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic               year_wrapped;
  } result_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? LEN_FEB_L : LEN_FEB;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: len = LEN_SHORT;
      default:   len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cds_clamp.sv
// Stage 1: clamps month and year, forms year / 25 by reciprocal multiply.
// Depends on cds_pkg.
`default_nettype none

module cds_clamp
  import cds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               vld_in,
  input  wire logic               op,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  output logic                    vld_r,
  output clamp_t                  data_r
);

  logic [YEAR_W-1:0]  year_c;
  logic [MONTH_W-1:0] month_c;
  logic [PROD_W-1:0]  prod;
  clamp_t             data_nxt;

  always_comb begin
    year_c   = (year > YEAR_MAX) ? YEAR_MAX : year;
    month_c  = (month > MONTH_DEC) ? MONTH_DEC : month;
    prod     = PROD_W'(year_c) * PROD_W'(RECIP_25);
    data_nxt = '{op: op, day: day, month: month_c, year: year_c,
                 quot: prod[RECIP_SHIFT +: QUOT_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cds_leap.sv
// Stage 2: leap test from the year / 25 quotient, month lengths.
// Depends on cds_pkg.
`default_nettype none

module cds_leap
  import cds_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   vld_in,
  input  wire clamp_t data_in,
  output logic        vld_r,
  output len_t        data_r
);

  logic [YEAR_W-1:0]  back;
  logic               div25;
  logic               leap;
  logic [MONTH_W-1:0] prev_m;
  len_t               data_nxt;

  always_comb begin
    back  = YEAR_W'(data_in.quot) * YEAR_W'(DIV_25);
    div25 = (back == data_in.year);
    // div by 100 = div by 4 and 25; div by 400 = div by 16 and 25
    leap  = (data_in.year[1:0] == 2'b00) && (!div25 || (data_in.year[3:0] == 4'h0));
    prev_m = (data_in.month == MONTH_JAN) ? MONTH_DEC : data_in.month - 4'd1;
    data_nxt = '{op: data_in.op, day: data_in.day, month: data_in.month,
                 year: data_in.year, len: month_len(data_in.month, leap),
                 prev_len: month_len(prev_m, leap)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cds_step.sv
// Stage 3: day, month and year roll for one step forward or back.
// Depends on cds_pkg.
`default_nettype none

module cds_step
  import cds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic vld_in,
  input  wire len_t data_in,
  output logic      vld_r,
  output result_t   data_r
);

  result_t res_nxt;
  logic [DAY_W-1:0] dec_day;

  always_comb begin
    res_nxt = '{new_day: data_in.day, new_month: data_in.month,
                new_year: data_in.year, year_wrapped: 1'b0};
    dec_day = data_in.day - 5'd1;
    if (data_in.op == OPC_ADD) begin
      if (data_in.day >= data_in.len) begin
        res_nxt.new_day = DAY_FIRST;
        if (data_in.month == MONTH_DEC) begin
          res_nxt.new_month = MONTH_JAN;
          if (data_in.year == YEAR_MAX) begin
            res_nxt.new_year     = YEAR_MIN;
            res_nxt.year_wrapped = 1'b1;
          end else begin
            res_nxt.new_year = data_in.year + 14'd1;
          end
        end else begin
          res_nxt.new_month = data_in.month + 4'd1;
        end
      end else begin
        res_nxt.new_day = data_in.day + 5'd1;
      end
    end else begin
      if (data_in.day <= DAY_FIRST) begin
        res_nxt.new_day = data_in.prev_len;
        if (data_in.month == MONTH_JAN) begin
          res_nxt.new_month = MONTH_DEC;
          if (data_in.year == YEAR_MIN) begin
            res_nxt.new_year     = YEAR_MAX;
            res_nxt.year_wrapped = 1'b1;
          end else begin
            res_nxt.new_year = data_in.year - 14'd1;
          end
        end else begin
          res_nxt.new_month = data_in.month - 4'd1;
        end
      end else begin
        // day past month length saturates to the last day
        res_nxt.new_day = (dec_day > data_in.len) ? data_in.len : dec_day;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_in) begin
      data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/calendar_date_step_core.sv
// Top level of the calendar date step core: three-stage pipeline.
// Depends on cds_pkg, cds_clamp, cds_leap, cds_step and the assertion header.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall  | opcode, day, month, year
//   out_    | output    | out_valid/out_stall| new_day, new_month, new_year, year_wrapped
//
// One beat in per cycle and one beat out per cycle while out_stall is
// low; an accepted beat passes through the stage registers of clamp +
// reciprocal multiply, leap test and month lengths, and day/month/year
// roll before out_valid rises.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stage moves on when it is empty or the stage after it moves, so
// bubbles collapse and in_stall rises only when all three stages hold a beat
// and out_stall is high.
`default_nettype none

`include "calendar_date_step_core_assert.svh"

module calendar_date_step_core
  import cds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic [DAY_W-1:0]   in_day,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [YEAR_W-1:0]  in_year,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DAY_W-1:0]        out_new_day,
  output logic [MONTH_W-1:0]      out_new_month,
  output logic [YEAR_W-1:0]       out_new_year,
  output logic                    out_year_wrapped
);

  logic    s1_vld, s2_vld, s3_vld;
  logic    s1_adv, s2_adv, s3_adv;
  clamp_t  s1_data;
  len_t    s2_data;
  result_t s3_data;

  // advance chain, from the output back to the input
  assign s3_adv   = !s3_vld || !out_stall;
  assign s2_adv   = !s2_vld || s3_adv;
  assign s1_adv   = !s1_vld || s2_adv;
  assign in_stall = !s1_adv;

  cds_clamp u_clamp (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .vld_in (in_valid),
    .op     (in_opcode),
    .day    (in_day),
    .month  (in_month),
    .year   (in_year),
    .vld_r  (s1_vld),
    .data_r (s1_data)
  );

  cds_leap u_leap (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s2_adv),
    .vld_in  (s1_vld),
    .data_in (s1_data),
    .vld_r   (s2_vld),
    .data_r  (s2_data)
  );

  cds_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s3_adv),
    .vld_in  (s2_vld),
    .data_in (s2_data),
    .vld_r   (s3_vld),
    .data_r  (s3_data)
  );

  assign out_valid        = s3_vld;
  assign out_new_day      = s3_data.new_day;
  assign out_new_month    = s3_data.new_month;
  assign out_new_year     = s3_data.new_year;
  assign out_year_wrapped = s3_data.year_wrapped;

  // a free output side never backs up to the input
  `CDS_ASSERT_IMPL(a_no_stall_when_drained, !out_stall, !in_stall)

  // every result has a nonzero day, a month up to December and a year up to 9999
  `CDS_ASSERT_IMPL(a_result_in_range, out_valid,
    (out_new_day != 5'd0) && (out_new_month <= MONTH_DEC) && (out_new_year <= YEAR_MAX))

  // a wrap only ever lands on 1 January 0 or 31 December 9999
  `CDS_ASSERT_IMPL(a_wrap_lands_on_edge, out_valid && out_year_wrapped,
    ((out_new_year == YEAR_MIN) && (out_new_month == MONTH_JAN) && (out_new_day == DAY_FIRST)) ||
    ((out_new_year == YEAR_MAX) && (out_new_month == MONTH_DEC) && (out_new_day == LEN_LONG)))

endmodule

`default_nettype wire

// File: dv/calendar_date_step_core_tb.sv
// Self-checking bench for calendar_date_step_core: a directed date table, then random dates.
// Depends on cds_pkg and the core RTL. Every result beat is checked against a typed or predicted date.
`default_nettype none

module calendar_date_step_core_tb
  import cds_pkg::*;
();

  localparam int RAND_PER_PHASE = 225;
  localparam int HOLD_CYCLES    = 60;   // long output hold-off, enough to back up the pipe
  localparam int SETTLE_CYCLES  = 20;   // extra wait after the drain loop, before the final check
  localparam int DRAIN_LIMIT    = 5000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_opcode = OPC_ADD;
  logic [DAY_W-1:0]    in_day = '0;
  logic [MONTH_W-1:0]  in_month = '0;
  logic [YEAR_W-1:0]   in_year = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DAY_W-1:0]    out_new_day;
  logic [MONTH_W-1:0]  out_new_month;
  logic [YEAR_W-1:0]   out_new_year;
  logic                out_year_wrapped;

  calendar_date_step_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_day           (in_day),
    .in_month         (in_month),
    .in_year          (in_year),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_day      (out_new_day),
    .out_new_month    (out_new_month),
    .out_new_year     (out_new_year),
    .out_year_wrapped (out_year_wrapped)
  );

  always #4 clk = ~clk;

  // Dates still owed by the core, oldest first.
  result_t pending_dates[$];

  int err_count  = 0;
  int n_offered  = 0;
  int n_checked  = 0;
  int n_wraps    = 0;
  int idle_pct   = 0;   // sender: chance per cycle of leaving a gap
  int stall_pct  = 0;   // receiver: chance per cycle of stalling
  int hold_req   = 0;   // bumped by the sender to ask for one long hold-off

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Gregorian month length; year 0 counts as a leap year (divisible by 400).
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic [YEAR_W-1:0]  y);
    bit leap;
    leap = ((y % 100) != 0) ? ((y % 4) == 0) : ((y % 400) == 0);
    if (m == MONTH_FEB) return leap ? 5'd29 : 5'd28;
    if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) return 5'd30;
    return 5'd31;
  endfunction

  function automatic result_t step_date(input logic               op,
                                        input logic [DAY_W-1:0]   d_in,
                                        input logic [MONTH_W-1:0] m_in,
                                        input logic [YEAR_W-1:0]  y_in);
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [DAY_W-1:0]   len;
    logic               wrap;
    result_t            r;
    // out-of-range month and year saturate before anything else
    d    = d_in;
    m    = (m_in > MONTH_DEC) ? MONTH_DEC : m_in;
    y    = (y_in > YEAR_MAX) ? YEAR_MAX : y_in;
    wrap = 1'b0;
    len  = days_in(m, y);
    if (op == OPC_ADD) begin
      // day at or past the month's end handled here (day zero steps to day one below)
      if (d >= len) begin
        d = DAY_FIRST;
        if (m == MONTH_DEC) begin
          m = MONTH_JAN;
          if (y == YEAR_MAX) begin
            y    = YEAR_MIN;
            wrap = 1'b1;
          end else begin
            y = y + 1'b1;
          end
        end else begin
          m = m + 1'b1;
        end
      end else begin
        d = d + 1'b1;
      end
    end else begin
      // day zero behaves as day one
      if (d <= DAY_FIRST) begin
        if (m == MONTH_JAN) begin
          m = MONTH_DEC;
          if (y == YEAR_MIN) begin
            y    = YEAR_MAX;
            wrap = 1'b1;
          end else begin
            y = y - 1'b1;
          end
        end else begin
          m = m - 1'b1;
        end
        d = days_in(m, y);
      end else begin
        d = d - 1'b1;
        if (d > len) d = len;   // day past the month's end lands on its last day
      end
    end
    r.new_day      = d;
    r.new_month    = m;
    r.new_year     = y;
    r.year_wrapped = wrap;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: expected dates typed in where they are obvious,
  // the rest ('0 with typed clear) go through the predictor.
  // --------------------------------------------------------------------------
  typedef struct {
    logic               op;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    bit                 typed;
    result_t            want;
  } date_case_t;

  localparam int N_DIRECTED = 23;

  date_case_t date_table [N_DIRECTED] = '{
    // year wraps at both ends
    '{OPC_ADD, 5'd31, MONTH_DEC, 14'd9999,  1'b1, '{5'd1,  MONTH_JAN, 14'd0,    1'b1}},
    '{OPC_SUB, 5'd1,  MONTH_JAN, 14'd0,     1'b1, '{5'd31, MONTH_DEC, 14'd9999, 1'b1}},
    // leap rule: year zero, non-leap century, leap century, ordinary leap year
    '{OPC_ADD, 5'd28, MONTH_FEB, 14'd0,     1'b1, '{5'd29, MONTH_FEB, 14'd0,    1'b0}},
    '{OPC_ADD, 5'd28, MONTH_FEB, 14'd1900,  1'b1, '{5'd1,  4'd2,      14'd1900, 1'b0}},
    '{OPC_ADD, 5'd28, MONTH_FEB, 14'd2000,  1'b1, '{5'd29, MONTH_FEB, 14'd2000, 1'b0}},
    '{OPC_SUB, 5'd1,  4'd2,      14'd2024,  1'b1, '{5'd29, MONTH_FEB, 14'd2024, 1'b0}},
    // year above range saturates to 9999
    '{OPC_ADD, 5'd31, MONTH_DEC, 14'd16383, 1'b1, '{5'd1,  MONTH_JAN, 14'd0,    1'b1}},
    '{OPC_SUB, 5'd1,  MONTH_JAN, 14'd16383, 1'b1, '{5'd31, MONTH_DEC, 14'd9998, 1'b0}},
    // day zero, both directions
    '{OPC_ADD, 5'd0,  MONTH_JUN, 14'd2023,  1'b1, '{5'd1,  MONTH_JUN, 14'd2023, 1'b0}},
    '{OPC_SUB, 5'd0,  MONTH_JAN, 14'd1,     1'b1, '{5'd31, MONTH_DEC, 14'd0,    1'b0}},
    // day past the month's length
    '{OPC_ADD, 5'd31, MONTH_APR, 14'd2023,  1'b1, '{5'd1,  4'd4,      14'd2023, 1'b0}},
    '{OPC_SUB, 5'd31, MONTH_APR, 14'd2023,  1'b1, '{5'd30, MONTH_APR, 14'd2023, 1'b0}},
    '{OPC_SUB, 5'd31, MONTH_FEB, 14'd2023,  1'b1, '{5'd28, MONTH_FEB, 14'd2023, 1'b0}},
    // month above range taken as December
    '{OPC_ADD, 5'd31, 4'd15,     14'd5000,  1'b1, '{5'd1,  MONTH_JAN, 14'd5001, 1'b0}},
    '{OPC_SUB, 5'd1,  4'd12,     14'd5000,  1'b1, '{5'd30, MONTH_NOV, 14'd5000, 1'b0}},
    // predictor rows
    '{OPC_ADD, 5'd29, MONTH_FEB, 14'd2024,  1'b0, '0},
    '{OPC_SUB, 5'd1,  4'd2,      14'd1900,  1'b0, '0},
    '{OPC_ADD, 5'd15, 4'd7,      14'd1234,  1'b0, '0},
    '{OPC_SUB, 5'd16, MONTH_NOV, 14'd9999,  1'b0, '0},
    '{OPC_ADD, 5'd30, MONTH_SEP, 14'd9999,  1'b0, '0},
    '{OPC_SUB, 5'd31, 4'd15,     14'd16383, 1'b0, '0},
    '{OPC_ADD, 5'd0,  MONTH_DEC, 14'd0,     1'b0, '0},
    '{OPC_SUB, 5'd31, MONTH_JAN, 14'd400,   1'b0, '0}
  };

  int phase_idle  [4] = '{0, 84, 0, 36};
  int phase_stall [4] = '{0, 0, 84, 36};

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  // Offer one date beat and hold it until taken. The expectation is queued on
  // the negedge before the accepting edge, so it is always ahead of its result.
  task automatic offer_beat(input logic op, input logic [DAY_W-1:0] d,
                            input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y,
                            input bit typed, input result_t want);
    bit taken;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_day    <= d;
    in_month  <= m;
    in_year   <= y;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) pending_dates.push_back(typed ? want : step_date(op, d, m, y));
      @(posedge clk);
    end while (!taken);
    n_offered++;
  endtask

  // Sender goes quiet until every owed date has come back.
  task automatic drain_dates();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  int hold_ack  = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: sampled at negedge, where the handshake is settled for
  // the coming edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        flag_error($sformatf("unexpected result beat %0d/%0d/%0d", out_new_day,
                             out_new_month, out_new_year));
      end else begin
        want = pending_dates.pop_front();
        if (out_new_day !== want.new_day)
          flag_error($sformatf("beat %0d new_day got %0d expected %0d", n_checked,
                               out_new_day, want.new_day));
        if (out_new_month !== want.new_month)
          flag_error($sformatf("beat %0d new_month got %0d expected %0d", n_checked,
                               out_new_month, want.new_month));
        if (out_new_year !== want.new_year)
          flag_error($sformatf("beat %0d new_year got %0d expected %0d", n_checked,
                               out_new_year, want.new_year));
        if (out_year_wrapped !== want.year_wrapped)
          flag_error($sformatf("beat %0d year_wrapped got %0b expected %0b", n_checked,
                               out_year_wrapped, want.year_wrapped));
        if (want.year_wrapped) n_wraps++;
        n_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic               r_op;
    logic [DAY_W-1:0]   r_d;
    logic [MONTH_W-1:0] r_m;
    logic [YEAR_W-1:0]  r_y;
    logic [DAY_W-1:0]   len;
    int                 waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (date_table[i])
      offer_beat(date_table[i].op, date_table[i].day, date_table[i].month,
                 date_table[i].year, date_table[i].typed, date_table[i].want);
    drain_dates();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      // first phase: hold the output for a long stretch while beats keep coming,
      // so the pipe fills and in_stall has to rise
      if (ph == 0) hold_req++;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        r_op = 1'($urandom_range(1));
        if ($urandom_range(99) < 85) begin
          // well-formed date, biased towards month ends and edge years
          case ($urandom_range(3))
            0:       r_y = YEAR_W'($urandom_range(9999));
            1:       r_y = $urandom_range(1) ? YEAR_W'($urandom_range(3))
                                             : YEAR_W'(9996 + $urandom_range(3));
            2:       r_y = YEAR_W'(100 * $urandom_range(99));
            default: r_y = YEAR_W'(4 * $urandom_range(2499));
          endcase
          r_m = MONTH_W'($urandom_range(11));
          len = days_in(r_m, r_y);
          case ($urandom_range(3))
            0:       r_d = DAY_FIRST;
            1:       r_d = len;
            2:       r_d = len - 1'b1;
            default: r_d = DAY_W'($urandom_range(len, 1));
          endcase
        end else begin
          // noise over the full port widths
          r_d = DAY_W'($urandom_range(31));
          r_m = MONTH_W'($urandom_range(15));
          r_y = YEAR_W'($urandom_range(16383));
        end
        offer_beat(r_op, r_d, r_m, r_y, 1'b0, '0);
      end
      if (ph == 1) drain_dates();
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    waited    = 0;
    while (pending_dates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_dates.size()));

    $display("Covered %0d dates (%0d directed), %0d results checked, %0d year wraps.",
             n_offered, N_DIRECTED, n_checked, n_wraps);
    $display("Idle/stall mixes 0/0, 84/0, 0/84, 36/36 plus a long output hold-off.");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
